### rtl/ascii_can_frame_codec_top_macros.svh
// Assertion macros shared by the codec checker.
`ifndef ASCII_CAN_FRAME_CODEC_TOP_MACROS_SVH
`define ASCII_CAN_FRAME_CODEC_TOP_MACROS_SVH

// Clocked assertion that is ignored while reset is applied.
`define ACFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ACFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/acfc_pkg.sv
// Shared types, constants and helper functions of the ASCII CAN frame codec.
package acfc_pkg;

    localparam int MAX_DATA_BYTES  = 8;
    localparam int BYTE_IDX_W      = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
    localparam int ID_DIGITS_SHORT = 3;
    localparam int ID_DIGITS_LONG  = 8;
    localparam int COUNT_W         = 10;
    localparam int COUNT_MAX       = 1023;
    localparam int Q_DEPTH         = 2;
    localparam int QPTR_W          = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W          = $clog2(Q_DEPTH + 1);
    localparam int POS_W           = 5;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_T_SHORT = 8'h74;
    localparam logic [7:0] CHAR_T_LONG  = 8'h54;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    typedef struct packed {
        logic       valid;
        logic [3:0] nib;
    } t_hex;

    typedef struct packed {
        logic        is_report;
        logic        mode_short;
        logic [31:0] id;
        logic [7:0]  dlc;
        logic [63:0] data;
        logic        ok;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.valid = 1'b0;
        h.nib   = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.valid = 1'b1;
            h.nib   = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            h.valid = 1'b1;
            h.nib   = c[3:0] + 4'd9;
        end
        return h;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        if (nib < 4'd10) begin
            return CHAR_ZERO + {4'd0, nib};
        end
        return base + {4'd0, nib} - 8'd10;
    endfunction

endpackage

### rtl/ascii_can_frame_codec_top.sv
// Top level of the serial-line ASCII CAN frame codec.
// The input stream carries one command per transaction: tuser 0 encodes the frame in
// tdata, tuser 1 feeds one received body character with tlast on the final one.
// Received characters are taken one per cycle while the queue has room; a body character
// that is not the last produces nothing, the last one produces a single frame report.
// An encode command produces 2 + id digits + 2 * min(dlc, 8) character transactions,
// 5 to 26 characters of the output stream, one character per cycle while tready is high;
// that expansion in the back end sets the sustained rate of encode commands.
// The first result of a command passes through the queue and then the output register
// before it is presented; a result still held by the receiver can delay it.
// A two-entry queue separates parsing from expansion, so new commands are taken while
// a burst is still being sent, until the queue is full.
// The configuration channel writes the id mode bit (1 for three id digits) and is
// always ready; the user must write it only while the block is idle; it is not checked.
// Reset clears the parser, the stored frame, the queue and the output valid, and sets
// the short id mode. When the receiver holds tready low, the output transaction holds
// and the queue fills, after which the input tready goes low.
module ascii_can_frame_codec_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // enc_id[28:0], enc_dlc[32:29], enc_data[96:33], rx_char[104:97], zero fill
    input  logic [111:0]  i_s_tdata,
    // command
    input  logic          i_s_tuser,
    input  logic          i_s_tlast,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // tx_char[7:0], dec_id[39:8], dec_dlc[47:40], dec_data[111:48],
    // dec_length_ok[112], zero fill
    output logic [119:0]  o_m_tdata,
    // result_kind
    output logic          o_m_tuser,
    output logic          o_m_tlast
);

    acfc_pkg::t_push  w_push;
    acfc_pkg::t_head  w_head;
    logic             w_full;
    logic             w_pop;
    logic [7:0]       w_tx_char;
    logic [31:0]      w_dec_id;
    logic [7:0]       w_dec_dlc;
    logic [63:0]      w_dec_data;
    logic             w_dec_ok;

    assign o_cfg_ready = 1'b1;

    acfc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_command  (i_s_tuser),
        .i_enc_id   (i_s_tdata[28:0]),
        .i_enc_dlc  (i_s_tdata[32:29]),
        .i_enc_data (i_s_tdata[96:33]),
        .i_rx_char  (i_s_tdata[104:97]),
        .i_rx_last  (i_s_tlast),
        .i_q_full   (w_full),
        .o_push     (w_push)
    );

    acfc_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_head (w_head)
    );

    acfc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (w_head),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_kind    (o_m_tuser),
        .o_tx_char (w_tx_char),
        .o_tx_last (o_m_tlast),
        .o_dec_id  (w_dec_id),
        .o_dec_dlc (w_dec_dlc),
        .o_dec_data(w_dec_data),
        .o_dec_ok  (w_dec_ok)
    );

    assign o_m_tdata = {7'd0, w_dec_ok, w_dec_data, w_dec_dlc, w_dec_id, w_tx_char};

endmodule

### rtl/acfc_front.sv
// Front end: accepts transactions, parses received characters and queues work.
module acfc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_command,
    input  logic [28:0]           i_enc_id,
    input  logic [3:0]            i_enc_dlc,
    input  logic [63:0]           i_enc_data,
    input  logic [7:0]            i_rx_char,
    input  logic                  i_rx_last,
    input  logic                  i_q_full,
    output acfc_pkg::t_push       o_push
);

    logic                              r_mode_short;
    logic [acfc_pkg::COUNT_W-1:0]      r_count, n_count;
    logic                              r_invalid, n_invalid;
    logic [3:0]                        r_half, n_half;
    logic [31:0]                       r_pid, n_pid;
    logic [7:0]                        r_pdlc, n_pdlc;
    logic [7:0]                        r_pbytes [acfc_pkg::MAX_DATA_BYTES];
    logic [7:0]                        n_pbytes [acfc_pkg::MAX_DATA_BYTES];
    logic [31:0]                       r_sid, n_sid;
    logic [7:0]                        r_sdlc, n_sdlc;
    logic [7:0]                        r_sbytes [8];
    logic [7:0]                        n_sbytes [8];
    logic                              w_accept;
    logic                              w_ok;
    acfc_pkg::t_hex                    w_hex;
    logic [acfc_pkg::COUNT_W-1:0]      w_idlen;
    logic [acfc_pkg::COUNT_W-1:0]      w_q;
    logic [acfc_pkg::COUNT_W-2:0]      w_idx;
    logic [63:0]                       w_packed;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_hex    = acfc_pkg::hex_value(i_rx_char);
    assign w_idlen  = r_mode_short ? acfc_pkg::COUNT_W'(acfc_pkg::ID_DIGITS_SHORT)
                                   : acfc_pkg::COUNT_W'(acfc_pkg::ID_DIGITS_LONG);
    assign w_q      = r_count - w_idlen - acfc_pkg::COUNT_W'(1);
    assign w_idx    = w_q[acfc_pkg::COUNT_W-1:1];

    always_comb begin
        n_count   = r_count;
        n_invalid = r_invalid;
        n_half    = r_half;
        n_pid     = r_pid;
        n_pdlc    = r_pdlc;
        n_pbytes  = r_pbytes;
        n_sid     = r_sid;
        n_sdlc    = r_sdlc;
        n_sbytes  = r_sbytes;
        w_ok      = 1'b0;
        if (w_accept && i_command == acfc_pkg::CMD_DECODE) begin
            if (r_count < w_idlen) begin
                if (!w_hex.valid) begin
                    n_invalid = 1'b1;
                end else begin
                    n_pid = {r_pid[27:0], w_hex.nib};
                end
            end else if (r_count == w_idlen) begin
                if (r_invalid) begin
                    n_pid = 32'd0;
                end
                n_invalid = 1'b0;
                n_pdlc    = i_rx_char - acfc_pkg::CHAR_ZERO;
            end else if (w_idx < (acfc_pkg::COUNT_W - 1)'(acfc_pkg::MAX_DATA_BYTES)) begin
                if (!w_q[0]) begin
                    n_half    = w_hex.valid ? w_hex.nib : 4'd0;
                    n_invalid = !w_hex.valid;
                end else begin
                    n_pbytes[w_idx[acfc_pkg::BYTE_IDX_W-1:0]] =
                        (r_invalid || !w_hex.valid) ? 8'd0 : {r_half, w_hex.nib};
                    n_invalid = 1'b0;
                end
            end
            if (r_count < acfc_pkg::COUNT_W'(acfc_pkg::COUNT_MAX)) begin
                n_count = r_count + acfc_pkg::COUNT_W'(1);
            end
            if (i_rx_last) begin
                if (n_count >= w_idlen + acfc_pkg::COUNT_W'(1)) begin
                    n_sid  = n_pid;
                    n_sdlc = n_pdlc;
                    if (n_pdlc <= 8'(acfc_pkg::MAX_DATA_BYTES) &&
                        n_count == w_idlen + acfc_pkg::COUNT_W'(1) + {1'b0, n_pdlc, 1'b0}) begin
                        for (int i = 0; i < acfc_pkg::MAX_DATA_BYTES; i++) begin
                            if (8'(i) < n_pdlc) begin
                                n_sbytes[i] = n_pbytes[i];
                            end
                        end
                        w_ok = 1'b1;
                    end
                end
                n_count   = '0;
                n_invalid = 1'b0;
                n_half    = 4'd0;
                n_pid     = 32'd0;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_packed[8*i +: 8] = n_sbytes[i];
        end
    end

    always_comb begin
        o_push.push             = w_accept && (i_command == acfc_pkg::CMD_ENCODE || i_rx_last);
        o_push.entry.mode_short = r_mode_short;
        if (i_command == acfc_pkg::CMD_ENCODE) begin
            o_push.entry.is_report = 1'b0;
            o_push.entry.id        = {3'd0, i_enc_id};
            o_push.entry.dlc       = {4'd0, i_enc_dlc};
            o_push.entry.data      = i_enc_data;
            o_push.entry.ok        = 1'b0;
        end else begin
            o_push.entry.is_report = 1'b1;
            o_push.entry.id        = n_sid;
            o_push.entry.dlc       = n_sdlc;
            o_push.entry.data      = w_packed;
            o_push.entry.ok        = w_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_short <= 1'b1;
            r_count      <= '0;
            r_invalid    <= 1'b0;
            r_half       <= 4'd0;
            r_pid        <= 32'd0;
            r_pdlc       <= 8'd0;
            r_sid        <= 32'd0;
            r_sdlc       <= 8'd0;
            for (int i = 0; i < 8; i++) begin
                r_sbytes[i] <= 8'd0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_mode_short <= i_cfg_data;
            end
            r_count   <= n_count;
            r_invalid <= n_invalid;
            r_half    <= n_half;
            r_pid     <= n_pid;
            r_pdlc    <= n_pdlc;
            r_sid     <= n_sid;
            r_sdlc    <= n_sdlc;
            r_sbytes  <= n_sbytes;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pbytes <= n_pbytes;
    end

endmodule

### rtl/acfc_fifo.sv
// Short queue of work entries between the front end and the back end.
module acfc_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  acfc_pkg::t_push  i_push,
    output logic             o_full,
    input  logic             i_pop,
    output acfc_pkg::t_head  o_head
);

    acfc_pkg::t_entry               r_mem [acfc_pkg::Q_DEPTH];
    logic [acfc_pkg::QPTR_W-1:0]    r_wr, n_wr;
    logic [acfc_pkg::QPTR_W-1:0]    r_rd, n_rd;
    logic [acfc_pkg::QCNT_W-1:0]    r_cnt, n_cnt;
    logic                           w_pop;

    assign o_full       = r_cnt == acfc_pkg::QCNT_W'(acfc_pkg::Q_DEPTH);
    assign o_head.valid = r_cnt != '0;
    assign o_head.entry = r_mem[r_rd];
    assign w_pop        = i_pop && o_head.valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push.push) begin
            n_wr = (r_wr == acfc_pkg::QPTR_W'(acfc_pkg::Q_DEPTH - 1)) ? '0
                                                                      : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == acfc_pkg::QPTR_W'(acfc_pkg::Q_DEPTH - 1)) ? '0
                                                                      : r_rd + 1'b1;
        end
        if (i_push.push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push.push && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

endmodule

### rtl/acfc_back.sv
// Back end: expands queued entries into result transactions and holds the output register.
module acfc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  acfc_pkg::t_head  i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_kind,
    output logic [7:0]       o_tx_char,
    output logic             o_tx_last,
    output logic [31:0]      o_dec_id,
    output logic [7:0]       o_dec_dlc,
    output logic [63:0]      o_dec_data,
    output logic             o_dec_ok
);

    logic [acfc_pkg::POS_W-1:0] r_pos, n_pos;
    logic                       r_valid, n_valid;
    logic                       r_kind;
    logic [7:0]                 r_char;
    logic                       r_last;
    logic [31:0]                r_id;
    logic [7:0]                 r_dlc;
    logic [63:0]                r_data;
    logic                       r_ok;
    logic                       w_load;
    logic [acfc_pkg::POS_W-1:0] w_idlen;
    logic [3:0]                 w_nbytes;
    logic [acfc_pkg::POS_W-1:0] w_nchars;
    logic [acfc_pkg::POS_W-1:0] w_sel;
    logic [acfc_pkg::POS_W-1:0] w_q;
    logic [7:0]                 w_byte;
    logic [7:0]                 w_char;
    logic                       w_last;

    assign w_load   = i_head.valid && (!r_valid || i_ready);
    assign w_idlen  = i_head.entry.mode_short ? acfc_pkg::POS_W'(acfc_pkg::ID_DIGITS_SHORT)
                                              : acfc_pkg::POS_W'(acfc_pkg::ID_DIGITS_LONG);
    assign w_nbytes = (i_head.entry.dlc[3:0] < 4'(acfc_pkg::MAX_DATA_BYTES))
                      ? i_head.entry.dlc[3:0] : 4'(acfc_pkg::MAX_DATA_BYTES);
    assign w_nchars = acfc_pkg::POS_W'(2) + w_idlen + {w_nbytes, 1'b0};
    assign w_sel    = w_idlen - r_pos;
    assign w_q      = r_pos - w_idlen - acfc_pkg::POS_W'(2);
    assign w_byte   = i_head.entry.data[8*w_q[3:1] +: 8];
    assign w_last   = r_pos == w_nchars - acfc_pkg::POS_W'(1);

    always_comb begin
        if (r_pos == '0) begin
            w_char = i_head.entry.mode_short ? acfc_pkg::CHAR_T_SHORT : acfc_pkg::CHAR_T_LONG;
        end else if (r_pos <= w_idlen) begin
            w_char = acfc_pkg::digit_char(i_head.entry.id[4*w_sel[2:0] +: 4], 1'b0);
        end else if (r_pos == w_idlen + acfc_pkg::POS_W'(1)) begin
            w_char = acfc_pkg::CHAR_ZERO + i_head.entry.dlc;
        end else begin
            w_char = acfc_pkg::digit_char(w_q[0] ? w_byte[3:0] : w_byte[7:4], 1'b1);
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_valid = r_valid;
        o_pop   = 1'b0;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (w_load) begin
            n_valid = 1'b1;
            if (i_head.entry.is_report || w_last) begin
                o_pop = 1'b1;
                n_pos = '0;
            end else begin
                n_pos = r_pos + acfc_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind <= i_head.entry.is_report;
            if (i_head.entry.is_report) begin
                r_char <= 8'd0;
                r_last <= 1'b0;
                r_id   <= i_head.entry.id;
                r_dlc  <= i_head.entry.dlc;
                r_data <= i_head.entry.data;
                r_ok   <= i_head.entry.ok;
            end else begin
                r_char <= w_char;
                r_last <= w_last;
                r_id   <= 32'd0;
                r_dlc  <= 8'd0;
                r_data <= 64'd0;
                r_ok   <= 1'b0;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_kind     = r_kind;
    assign o_tx_char  = r_char;
    assign o_tx_last  = r_last;
    assign o_dec_id   = r_id;
    assign o_dec_dlc  = r_dlc;
    assign o_dec_data = r_data;
    assign o_dec_ok   = r_ok;

endmodule

### rtl/acfc_checker.sv
// Port-level checker for the ASCII CAN frame codec and its binding.
`include "ascii_can_frame_codec_top_macros.svh"

module acfc_port_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_m_tready,
    input  logic          o_m_tvalid,
    input  logic [119:0]  o_m_tdata,
    input  logic          o_m_tuser,
    input  logic          o_m_tlast
);

    `ACFC_ASSERT_ALWAYS(a_no_valid_after_reset, i_clk, !i_rst_n |=> !o_m_tvalid, "Output valid right after reset")
    `ACFC_ASSERT(a_stall_holds, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata), "Stalled output transaction changed")
    `ACFC_ASSERT(a_report_clean, i_clk, i_rst_n, o_m_tvalid && o_m_tuser |-> !o_m_tlast && o_m_tdata[7:0] == 8'd0, "Frame report carries character fields")
    `ACFC_ASSERT(a_char_clean, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser |-> o_m_tdata[119:8] == 112'd0, "Encoded character carries frame fields")

endmodule

bind ascii_can_frame_codec_top acfc_port_checker u_acfc_port_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_m_tready(i_m_tready),
    .o_m_tvalid(o_m_tvalid),
    .o_m_tdata (o_m_tdata),
    .o_m_tuser (o_m_tuser),
    .o_m_tlast (o_m_tlast)
);
